// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/imu_srf_pkg.sv =====
// ----------------------------------------------------------------------------
// imu_srf_pkg
// Shared constants and address decode for the sensor register file.
// ----------------------------------------------------------------------------
`default_nettype none

package imu_srf_pkg;

   localparam int QUEUE_DEPTH = 1024;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_DEPTH = 128;

   localparam logic [1:0] OP_SELECT   = 2'd0;
   localparam logic [1:0] OP_XFER     = 2'd1;
   localparam logic [1:0] OP_DESELECT = 2'd2;
   localparam logic [1:0] OP_SAMPLE   = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_PROTECTED = 2'd1;
   localparam logic [1:0] ST_MODE_REJ  = 2'd2;
   localparam logic [1:0] ST_RSVD_START = 2'd3;

   localparam logic [6:0] ADDR_OUT_L     = 7'h3E;
   localparam logic [6:0] ADDR_OUT_H     = 7'h3F;
   localparam logic [6:0] ADDR_CTRL3     = 7'h12;
   localparam logic [6:0] ADDR_FIFO_CTRL = 7'h0A;
   localparam logic [6:0] ADDR_PULSE_CFG = 7'h0B;
   localparam logic [6:0] ADDR_ID        = 7'h0F;

   localparam logic [7:0] ID_RESET    = 8'b01101010;
   localparam logic [7:0] CTRL3_RESET = 8'b00000100;
   localparam logic [7:0] CTRL3_MASK  = 8'hFE;
   localparam int BDU_BIT      = 6;
   localparam int AUTO_INC_BIT = 2;
   localparam int REBOOT_BIT   = 7;

   localparam logic [2:0] MODE_BYPASS = 3'd0;
   localparam logic [2:0] MODE_FIFO   = 3'd1;

   function automatic logic is_reserved(input logic [6:0] a);
      logic r;
      r = a inside {7'h00, 7'h02, 7'h0C, 7'h1F, [7'h43:7'h48], 7'h56, 7'h57,
                    [7'h61:7'h65], [7'h6C:7'h72], [7'h76:7'h7F]};
      return r;
   endfunction

   function automatic logic is_readonly(input logic [6:0] a);
      logic r;
      r = a inside {7'h0F, [7'h1B:7'h1E], [7'h20:7'h29], [7'h30:7'h41],
                    [7'h49:7'h51], [7'h53:7'h55], [7'h66:7'h6B]};
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/imu_srf_if.sv =====
// ----------------------------------------------------------------------------
// imu_srf_if
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
`default_nettype none

interface imu_srf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [7:0]  byte_in;
   logic [15:0] sample_word;
   modport source (output valid, operation, byte_in, sample_word, input ready);
   modport sink   (input valid, operation, byte_in, sample_word, output ready);
endinterface

interface imu_srf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       read_valid;
   logic [1:0] status;
   modport source (output valid, read_data, read_valid, status, input ready);
   modport sink   (input valid, read_data, read_valid, status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/imu_spi_register_file_fifo_top.sv =====
// ----------------------------------------------------------------------------
// imu_spi_register_file_fifo_top
// Register file and sample queue behind a motion-sensor SPI slave.
// ----------------------------------------------------------------------------
// One item is in work at a time. After acceptance, a select, a deselect, a
// sample or an ignored transfer passes from the execute state to the done
// state; a write adds the increment state, and a read adds a read-data state
// before the increment state. The next item is taken in the cycle the
// response appears. Refilling the data-out registers from the queue adds a
// queue memory read step and a load step, each reserved address skipped by
// auto-increment on a read adds another increment step, and a stalled
// response holds the block until it leaves. The 128-byte register store is a
// single-port synchronous memory and the sample queue a dual-port one, written
// at the tail and read at the head, both with registered reads; the register
// store carries one valid bit per entry, so reset and reboot take effect at once.
`default_nettype none

module imu_spi_register_file_fifo_top (
   input  wire logic      clock,
   input  wire logic      reset,
   imu_srf_req_if.sink    req_ch,
   imu_srf_rsp_if.source  rsp_ch
);
   import imu_srf_pkg::*;
   `include "assert_macros.svh"

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_EXEC    = 3'd1;
   localparam logic [2:0] S_RDATA   = 3'd2;
   localparam logic [2:0] S_LOAD_RD = 3'd3;
   localparam logic [2:0] S_LOAD_WR = 3'd4;
   localparam logic [2:0] S_INC     = 3'd5;
   localparam logic [2:0] S_DONE    = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0]  op_ff;
   logic [7:0]  byte_ff;
   logic [15:0] sample_ff;

   logic [6:0] addr_ff, addr_in;
   logic is_read_ff, is_read_in, open_ff, open_in;
   logic fifo_mode_ff, fifo_mode_in, samp_en_ff, samp_en_in;
   logic lo_ff, lo_in, hi_ff, hi_in, loaded_ff, loaded_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [7:0] ctrl3_ff, ctrl3_in, out_l_ff, out_l_in, out_h_ff, out_h_in;
   logic [7:0] res_data_ff, res_data_in;
   logic res_valid_ff, res_valid_in;
   logic [1:0] res_status_ff, res_status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff;
   logic rsp_rvalid_ff;
   logic [1:0] rsp_status_ff;

   // register store
   logic [7:0] store_mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] store_valid_ff;
   logic [7:0] store_q_ff, store_wd, store_rd;
   logic store_we, store_clear;

   // sample queue
   logic [15:0] queue_mem [QUEUE_DEPTH];
   logic [15:0] queue_q_ff;
   logic queue_we;

   logic req_fire, rsp_load;
   logic [3:0] rate;
   logic [2:0] mode;
   logic [7:0] ctrl3_wr;
   logic [6:0] addr_inc;
   logic lo_now, hi_now, refill;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_data  = rsp_data_ff;
   assign rsp_ch.read_valid = rsp_rvalid_ff;
   assign rsp_ch.status     = rsp_status_ff;

   assign rate     = byte_ff[6:3];
   assign mode     = byte_ff[2:0];
   assign ctrl3_wr = byte_ff & CTRL3_MASK;
   assign addr_inc = addr_ff + 7'd1;
   assign lo_now   = lo_ff || (addr_ff == ADDR_OUT_L);
   assign hi_now   = hi_ff || (addr_ff == ADDR_OUT_H);
   assign refill   = ctrl3_ff[BDU_BIT] ? (lo_now && hi_now) : (lo_now || hi_now);
   assign store_wd = byte_ff;

   always_comb begin
      case (addr_ff)
         ADDR_CTRL3: store_rd = ctrl3_ff;
         ADDR_OUT_L: store_rd = out_l_ff;
         ADDR_OUT_H: store_rd = out_h_ff;
         default: begin
            if (store_valid_ff[addr_ff]) store_rd = store_q_ff;
            else if (addr_ff == ADDR_ID) store_rd = ID_RESET;
            else store_rd = 8'd0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      addr_in = addr_ff; is_read_in = is_read_ff; open_in = open_ff;
      fifo_mode_in = fifo_mode_ff; samp_en_in = samp_en_ff;
      lo_in = lo_ff; hi_in = hi_ff; loaded_in = loaded_ff;
      count_in = count_ff; head_in = head_ff; tail_in = tail_ff;
      ctrl3_in = ctrl3_ff; out_l_in = out_l_ff; out_h_in = out_h_ff;
      res_data_in = res_data_ff; res_valid_in = res_valid_ff;
      res_status_in = res_status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      store_we = 1'b0; store_clear = 1'b0; queue_we = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_EXEC;
         end
         S_EXEC: begin
            res_data_in = 8'd0; res_valid_in = 1'b0; res_status_in = ST_OK;
            state_in = S_DONE;
            case (op_ff)
               OP_SELECT: begin
                  addr_in = byte_ff[7:1];
                  is_read_in = byte_ff[0];
                  open_in = 1'b1;
                  if (byte_ff[0] && is_reserved(byte_ff[7:1])) res_status_in = ST_RSVD_START;
               end
               OP_XFER: begin
                  if (open_ff && is_read_ff) begin
                     state_in = S_RDATA;
                  end else if (open_ff) begin
                     state_in = S_INC;
                     case (addr_ff)
                        ADDR_FIFO_CTRL: begin
                           samp_en_in = rate inside {[4'd1:4'd10]};
                           if (mode != MODE_BYPASS && mode != MODE_FIFO) begin
                              res_status_in = ST_MODE_REJ;
                           end else begin
                              fifo_mode_in = (mode == MODE_FIFO);
                              store_we = 1'b1;
                              if (mode == MODE_BYPASS) begin
                                 count_in = '0; head_in = '0; tail_in = '0;
                                 lo_in = 1'b0; hi_in = 1'b0;
                              end else if (!fifo_mode_ff) begin
                                 state_in = S_LOAD_RD;
                              end
                           end
                        end
                        ADDR_PULSE_CFG: store_we = 1'b1;
                        ADDR_CTRL3: begin
                           if (ctrl3_wr[REBOOT_BIT]) begin
                              store_clear = 1'b1;
                              ctrl3_in = CTRL3_RESET;
                              out_l_in = 8'd0; out_h_in = 8'd0;
                           end else begin
                              ctrl3_in = ctrl3_wr;
                           end
                        end
                        default: begin
                           if (is_readonly(addr_ff) || is_reserved(addr_ff))
                              res_status_in = ST_PROTECTED;
                           else
                              store_we = 1'b1;
                        end
                     endcase
                  end
               end
               OP_DESELECT: open_in = 1'b0;
               default: begin
                  if (samp_en_ff && count_ff != COUNT_W'(QUEUE_DEPTH)) begin
                     queue_we = 1'b1;
                     tail_in = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                     count_in = count_ff + 1'b1;
                     if (!loaded_ff) state_in = S_LOAD_RD;
                  end
               end
            endcase
         end
         S_RDATA: begin
            res_data_in = store_rd;
            res_valid_in = 1'b1;
            lo_in = lo_now; hi_in = hi_now;
            state_in = refill ? S_LOAD_RD : S_INC;
         end
         S_LOAD_RD: begin
            if (count_ff == '0) begin
               loaded_in = 1'b0;
               state_in = (op_ff == OP_XFER) ? S_INC : S_DONE;
            end else begin
               state_in = S_LOAD_WR;
            end
         end
         S_LOAD_WR: begin
            out_l_in = queue_q_ff[7:0];
            out_h_in = queue_q_ff[15:8];
            head_in = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
            lo_in = 1'b0; hi_in = 1'b0; loaded_in = 1'b1;
            state_in = (op_ff == OP_XFER) ? S_INC : S_DONE;
         end
         S_INC: begin
            state_in = S_DONE;
            if (ctrl3_ff[AUTO_INC_BIT]) begin
               addr_in = addr_inc;
               // keep stepping past reserved addresses on reads
               if (is_read_ff && is_reserved(addr_inc)) state_in = S_INC;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         addr_ff <= '0; is_read_ff <= 1'b0; open_ff <= 1'b0;
         fifo_mode_ff <= 1'b0; samp_en_ff <= 1'b0;
         lo_ff <= 1'b0; hi_ff <= 1'b0; loaded_ff <= 1'b0;
         count_ff <= '0; head_ff <= '0; tail_ff <= '0;
         ctrl3_ff <= CTRL3_RESET; out_l_ff <= 8'd0; out_h_ff <= 8'd0;
         rsp_valid_ff <= 1'b0;
         store_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in; is_read_ff <= is_read_in; open_ff <= open_in;
         fifo_mode_ff <= fifo_mode_in; samp_en_ff <= samp_en_in;
         lo_ff <= lo_in; hi_ff <= hi_in; loaded_ff <= loaded_in;
         count_ff <= count_in; head_ff <= head_in; tail_ff <= tail_in;
         ctrl3_ff <= ctrl3_in; out_l_ff <= out_l_in; out_h_ff <= out_h_in;
         rsp_valid_ff <= rsp_valid_in;
         if (store_clear) store_valid_ff <= '0;
         else if (store_we) store_valid_ff[addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff <= req_ch.operation;
         byte_ff <= req_ch.byte_in;
         sample_ff <= req_ch.sample_word;
      end
      res_data_ff <= res_data_in;
      res_valid_ff <= res_valid_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_data_ff <= res_data_ff;
         rsp_rvalid_ff <= res_valid_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) store_mem[addr_ff] <= store_wd;
      store_q_ff <= store_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (queue_we) queue_mem[tail_ff] <= sample_ff;
      queue_q_ff <= queue_mem[head_ff];
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= COUNT_W'(QUEUE_DEPTH))
   `ASSERT_ALWAYS(a_empty_ptrs, clock, reset, (count_ff != '0) || (head_ff == tail_ff))
   `ASSERT_NEXT(a_write_inc_once, clock, reset, (state_ff == S_INC) && !is_read_ff, state_ff == S_DONE)
   `ASSERT_NEXT(a_load_pop, clock, reset, state_ff == S_LOAD_WR, loaded_ff && !lo_ff && !hi_ff)

endmodule

`default_nettype wire
